@@ design/text_terminal_cell_engine_assert.svh @@
// assertion macros for the text terminal cell engine
`ifndef TEXT_TERMINAL_CELL_ENGINE_ASSERT_SVH
`define TEXT_TERMINAL_CELL_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define TTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tte assertion failed");
// next-cycle implication, checked outside reset
`define TTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tte assertion failed");
`else
`define TTE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TTE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/tte_pkg.sv @@
package tte_pkg;

    localparam int unsigned POS_W   = 12;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned COLOR_W = 16;

    localparam logic [POS_W-1:0]  COMMAND_LIMIT = 12'd126;
    localparam logic [CHAR_W-1:0] BLANK_CHAR    = 8'h20;
    localparam logic [CHAR_W-1:0] BLINK_BIT     = 8'h80;
    localparam logic [CHAR_W-1:0] SYM_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] SYM_LF        = 8'd10;

    // operation codes
    localparam logic [3:0] OP_CLEAR      = 4'd0;
    localparam logic [3:0] OP_PUTCHAR    = 4'd1;
    localparam logic [3:0] OP_LEFT       = 4'd2;
    localparam logic [3:0] OP_RIGHT      = 4'd3;
    localparam logic [3:0] OP_UP         = 4'd4;
    localparam logic [3:0] OP_DOWN       = 4'd5;
    localparam logic [3:0] OP_BACKSPACE  = 4'd6;
    localparam logic [3:0] OP_INSERT     = 4'd7;
    localparam logic [3:0] OP_TICK       = 4'd8;
    localparam logic [3:0] OP_CURSOR_ON  = 4'd9;
    localparam logic [3:0] OP_CURSOR_OFF = 4'd10;
    localparam logic [3:0] OP_MARK       = 4'd11;
    localparam logic [3:0] OP_GROW       = 4'd12;
    localparam logic [3:0] OP_SHRINK     = 4'd13;
    localparam logic [3:0] OP_READ       = 4'd14;
    // unused code, still answered with a result
    localparam logic [3:0] OP_NOP        = 4'd15;

    // register indexes
    localparam logic [2:0] REG_COLUMNS_LOG2   = 3'd0;
    localparam logic [2:0] REG_ROWS_LOG2      = 3'd1;
    localparam logic [2:0] REG_BLINK_INTERVAL = 3'd2;
    localparam logic [2:0] REG_EDITING_MODE   = 3'd3;
    localparam logic [2:0] REG_CLEAR_FG       = 3'd4;
    localparam logic [2:0] REG_CLEAR_BG       = 3'd5;
    localparam logic [2:0] REG_PEN_FG         = 3'd6;
    localparam logic [2:0] REG_PEN_BG         = 3'd7;

    typedef struct packed {
        logic [2:0]         columns_log2;
        logic [2:0]         rows_log2;
        logic [7:0]         blink_interval;
        logic               editing_mode;
        logic [COLOR_W-1:0] clear_foreground;
        logic [COLOR_W-1:0] clear_background;
        logic [COLOR_W-1:0] pen_foreground;
        logic [COLOR_W-1:0] pen_background;
    } t_cfg;

    typedef struct packed {
        logic [CHAR_W-1:0]  symbol;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
    } t_cell;

    typedef struct packed {
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
        logic             wr_en;
        logic             wr_symbol;
        logic             wr_fg;
        logic             wr_bg;
        logic [POS_W-1:0] wr_addr;
        t_cell            wr_data;
    } t_mem_req;

    typedef struct packed {
        logic [3:0]        operation;
        logic [CHAR_W-1:0] symbol;
        logic [POS_W-1:0]  tile_address;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]   cursor_pos;
        logic [CHAR_W-1:0]  tile_char;
        logic [COLOR_W-1:0] tile_fg;
        logic [COLOR_W-1:0] tile_bg;
        logic               command_full;
        logic               blink_active;
    } t_out_item;

endpackage

@@ design/tte_store.sv @@
module tte_store (
    input  logic             i_clk,
    input  tte_pkg::t_mem_req i_req,
    output tte_pkg::t_cell   o_rd_cell
);
    import tte_pkg::*;

    logic [CHAR_W-1:0]  r_mem_symbol [1<<POS_W];
    logic [COLOR_W-1:0] r_mem_fg     [1<<POS_W];
    logic [COLOR_W-1:0] r_mem_bg     [1<<POS_W];
    t_cell              r_rd_cell;

    // per-field write enables
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && i_req.wr_symbol) begin
            r_mem_symbol[i_req.wr_addr] <= i_req.wr_data.symbol;
        end
        if (i_req.wr_en && i_req.wr_fg) begin
            r_mem_fg[i_req.wr_addr] <= i_req.wr_data.fg;
        end
        if (i_req.wr_en && i_req.wr_bg) begin
            r_mem_bg[i_req.wr_addr] <= i_req.wr_data.bg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_cell.symbol <= r_mem_symbol[i_req.rd_addr];
            r_rd_cell.fg     <= r_mem_fg[i_req.rd_addr];
            r_rd_cell.bg     <= r_mem_bg[i_req.rd_addr];
        end
    end

    assign o_rd_cell = r_rd_cell;

endmodule

@@ design/tte_regs.sv @@
module tte_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output tte_pkg::t_cfg o_cfg
);
    import tte_pkg::*;

    t_cfg       r_cfg;
    logic       wr_go;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_go   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns_log2     <= 3'd6;
            r_cfg.rows_log2        <= 3'd5;
            r_cfg.blink_interval   <= 8'd20;
            r_cfg.editing_mode     <= 1'b0;
            r_cfg.clear_foreground <= '0;
            r_cfg.clear_background <= '0;
            r_cfg.pen_foreground   <= '0;
            r_cfg.pen_background   <= '0;
        end else if (wr_go) begin
            case (reg_idx)
                REG_COLUMNS_LOG2:   r_cfg.columns_log2     <= pwdata[2:0];
                REG_ROWS_LOG2:      r_cfg.rows_log2        <= pwdata[2:0];
                REG_BLINK_INTERVAL: r_cfg.blink_interval   <= pwdata[7:0];
                REG_EDITING_MODE:   r_cfg.editing_mode     <= pwdata[0];
                REG_CLEAR_FG:       r_cfg.clear_foreground <= pwdata[15:0];
                REG_CLEAR_BG:       r_cfg.clear_background <= pwdata[15:0];
                REG_PEN_FG:         r_cfg.pen_foreground   <= pwdata[15:0];
                REG_PEN_BG:         r_cfg.pen_background   <= pwdata[15:0];
                default:            r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_COLUMNS_LOG2:   prdata = {29'd0, r_cfg.columns_log2};
            REG_ROWS_LOG2:      prdata = {29'd0, r_cfg.rows_log2};
            REG_BLINK_INTERVAL: prdata = {24'd0, r_cfg.blink_interval};
            REG_EDITING_MODE:   prdata = {31'd0, r_cfg.editing_mode};
            REG_CLEAR_FG:       prdata = {16'd0, r_cfg.clear_foreground};
            REG_CLEAR_BG:       prdata = {16'd0, r_cfg.clear_background};
            REG_PEN_FG:         prdata = {16'd0, r_cfg.pen_foreground};
            REG_PEN_BG:         prdata = {16'd0, r_cfg.pen_background};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/tte_seq.sv @@
`include "text_terminal_cell_engine_assert.svh"
module tte_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tte_pkg::t_cfg       i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tte_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tte_pkg::t_out_item  o_out_item,
    output tte_pkg::t_mem_req   o_mem,
    input  tte_pkg::t_cell      i_rd_cell
);
    import tte_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUT    = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;
    localparam logic [2:0] S_RDW    = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    // sweep kinds
    localparam logic [1:0] M_FILL   = 2'd0;
    localparam logic [1:0] M_SCROLL = 2'd1;
    localparam logic [1:0] M_DOWN   = 2'd2;
    localparam logic [1:0] M_UP     = 2'd3;

    // pending write kinds
    localparam logic [1:0] K_FILL    = 2'd0;
    localparam logic [1:0] K_COPY    = 2'd1;
    localparam logic [1:0] K_BLANKCH = 2'd2;

    logic [2:0]        r_state, n_state;
    logic [3:0]        r_op, n_op;
    logic [POS_W-1:0]  r_cursor, n_cursor, r_cs, n_cs, r_ce, n_ce;
    logic              r_blink, n_blink;
    logic [7:0]        r_cd, n_cd;
    logic [CHAR_W-1:0] r_saved, n_saved, r_sym, n_sym;
    logic              r_put_fg, n_put_fg, r_scroll_pend, n_scroll_pend;
    logic [POS_W-1:0]  r_idx, n_idx, r_last, n_last, r_blank_pos, n_blank_pos;
    logic [1:0]        r_mode, n_mode;
    logic              r_after_blank, n_after_blank;
    logic              r_pv, n_pv;
    logic [POS_W-1:0]  r_pdst, n_pdst;
    logic [1:0]        r_pkind, n_pkind;
    logic              r_ov, n_ov;
    t_out_item         r_out, n_out;
    t_cell             r_rd_cell, n_rd_cell;
    t_mem_req          mem;

    logic [3:0]        lg_sum, lg_cells;
    logic [POS_W:0]    cols, ncells, keep, cmask13, nxt, endp;
    logic [POS_W-1:0]  cols12, cmask12, aligned, nc, nce, bpos, lim;
    logic [1:0]        kind;

    // screen geometry, cell count clamped to the store
    assign lg_sum   = {1'b0, i_cfg.columns_log2} + {1'b0, i_cfg.rows_log2};
    assign lg_cells = (lg_sum > 4'd12) ? 4'd12 : lg_sum;
    assign cols     = (POS_W+1)'(1) << i_cfg.columns_log2;
    assign ncells   = (POS_W+1)'(1) << lg_cells;
    assign keep     = ncells - cols;
    assign cmask13  = cols - (POS_W+1)'(1);
    assign cols12   = cols[POS_W-1:0];
    assign cmask12  = cmask13[POS_W-1:0];
    assign aligned  = r_cursor & ~cmask12;

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_cursor      = r_cursor;
        n_cs          = r_cs;
        n_ce          = r_ce;
        n_blink       = r_blink;
        n_cd          = r_cd;
        n_saved       = r_saved;
        n_sym         = r_sym;
        n_put_fg      = r_put_fg;
        n_scroll_pend = r_scroll_pend;
        n_idx         = r_idx;
        n_last        = r_last;
        n_blank_pos   = r_blank_pos;
        n_mode        = r_mode;
        n_after_blank = r_after_blank;
        n_pv          = 1'b0;
        n_pdst        = r_pdst;
        n_pkind       = r_pkind;
        n_ov          = r_ov && i_out_stall;
        n_out         = r_out;
        n_rd_cell     = r_rd_cell;
        nxt           = '0;
        endp          = '0;
        nc            = '0;
        nce           = '0;
        bpos          = '0;
        lim           = '0;
        kind          = K_FILL;
        mem           = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op          = i_in_item.operation;
                    n_rd_cell     = '0;
                    n_state       = S_FINISH;
                    n_after_blank = 1'b0;
                    n_scroll_pend = 1'b0;
                    case (i_in_item.operation)
                        OP_CLEAR: begin
                            n_mode   = M_FILL;
                            n_idx    = '0;
                            n_last   = POS_W'(ncells - (POS_W+1)'(1));
                            n_state  = S_SWEEP;
                            n_cursor = '0;
                            n_cs     = '0;
                            n_ce     = '0;
                        end
                        OP_PUTCHAR: begin
                            if (i_in_item.symbol == SYM_CR) begin
                                n_cursor = aligned;
                            end else if (i_in_item.symbol == SYM_LF) begin
                                if ({1'b0, aligned} >= keep) begin
                                    n_mode   = M_SCROLL;
                                    n_idx    = '0;
                                    n_last   = POS_W'(ncells - (POS_W+1)'(1));
                                    n_state  = S_SWEEP;
                                    n_cs     = r_cs - cols12;
                                    n_ce     = r_ce - cols12;
                                    n_cursor = aligned;
                                end else begin
                                    n_cursor = aligned + cols12;
                                end
                            end else begin
                                n_state  = S_PUT;
                                n_idx    = r_cursor;
                                n_sym    = i_in_item.symbol;
                                n_put_fg = 1'b1;
                                nxt      = {1'b0, r_cursor} + (POS_W+1)'(1);
                                if (nxt >= ncells) begin
                                    n_scroll_pend = 1'b1;
                                    n_cs          = r_cs - cols12;
                                    n_ce          = r_ce - cols12;
                                    nxt           = nxt - cols;
                                end
                                n_cursor = nxt[POS_W-1:0];
                            end
                        end
                        OP_LEFT: begin
                            lim = i_cfg.editing_mode ? r_cs : '0;
                            if (r_cursor > lim) begin
                                n_cursor = r_cursor - POS_W'(1);
                            end
                        end
                        OP_RIGHT: begin
                            nxt = {1'b0, r_cursor} + (POS_W+1)'(1);
                            if (i_cfg.editing_mode) begin
                                if (nxt <= {1'b0, r_ce}) begin
                                    n_cursor = nxt[POS_W-1:0];
                                end
                            end else begin
                                if (nxt >= ncells) begin
                                    n_mode  = M_SCROLL;
                                    n_idx   = '0;
                                    n_last  = POS_W'(ncells - (POS_W+1)'(1));
                                    n_state = S_SWEEP;
                                    n_cs    = r_cs - cols12;
                                    n_ce    = r_ce - cols12;
                                    nxt     = nxt - cols;
                                end
                                n_cursor = nxt[POS_W-1:0];
                            end
                        end
                        OP_UP: begin
                            nxt = {1'b0, r_cursor} - cols;
                            if (!i_cfg.editing_mode && ({1'b0, r_cursor} >= cols)
                                && (nxt < ncells)) begin
                                n_cursor = nxt[POS_W-1:0];
                            end
                        end
                        OP_DOWN: begin
                            if (!i_cfg.editing_mode) begin
                                nxt = {1'b0, r_cursor} + cols;
                                if (nxt >= ncells) begin
                                    n_mode  = M_SCROLL;
                                    n_idx   = '0;
                                    n_last  = POS_W'(ncells - (POS_W+1)'(1));
                                    n_state = S_SWEEP;
                                    n_cs    = r_cs - cols12;
                                    n_ce    = r_ce - cols12;
                                    nxt     = nxt - cols;
                                end
                                n_cursor = nxt[POS_W-1:0];
                            end
                        end
                        OP_BACKSPACE: begin
                            if (i_cfg.editing_mode) begin
                                if (r_cursor > r_cs) begin
                                    nc          = r_cursor - POS_W'(1);
                                    nce         = r_ce - POS_W'(1);
                                    n_cursor    = nc;
                                    n_ce        = nce;
                                    n_blank_pos = nce;
                                    if (nc < nce) begin
                                        n_mode        = M_DOWN;
                                        n_idx         = nc;
                                        n_last        = nce - POS_W'(1);
                                        n_after_blank = 1'b1;
                                        n_state       = S_SWEEP;
                                    end else begin
                                        n_state = S_BLANK;
                                    end
                                end
                            end else if (r_cursor != '0) begin
                                nc          = r_cursor - POS_W'(1);
                                endp        = ({1'b0, r_cursor} + cmask13) & ~cmask13;
                                bpos        = POS_W'(endp - (POS_W+1)'(1));
                                n_cursor    = nc;
                                n_blank_pos = bpos;
                                if (nc < bpos) begin
                                    n_mode        = M_DOWN;
                                    n_idx         = nc;
                                    n_last        = bpos - POS_W'(1);
                                    n_after_blank = 1'b1;
                                    n_state       = S_SWEEP;
                                end else begin
                                    n_state = S_BLANK;
                                end
                            end
                        end
                        OP_INSERT: begin
                            if (r_ce > r_cursor) begin
                                n_mode  = M_UP;
                                n_idx   = r_ce;
                                n_last  = r_cursor + POS_W'(1);
                                n_state = S_SWEEP;
                            end
                        end
                        OP_TICK: begin
                            if (r_blink) begin
                                if (r_cd == 8'd0) begin
                                    n_cd    = i_cfg.blink_interval - 8'd1;
                                    n_idx   = r_cursor;
                                    n_state = S_RD;
                                end else begin
                                    n_cd = r_cd - 8'd1;
                                end
                            end
                        end
                        OP_CURSOR_ON: begin
                            n_blink = 1'b1;
                            n_cd    = '0;
                            n_idx   = r_cursor;
                            n_state = S_RD;
                        end
                        OP_CURSOR_OFF: begin
                            n_blink  = 1'b0;
                            n_idx    = r_cursor;
                            n_sym    = r_saved;
                            n_put_fg = 1'b0;
                            n_state  = S_PUT;
                        end
                        OP_MARK: begin
                            n_cs = r_cursor;
                            n_ce = r_cursor;
                        end
                        OP_GROW:   n_ce = r_ce + POS_W'(1);
                        OP_SHRINK: n_ce = r_ce - POS_W'(1);
                        OP_READ: begin
                            n_idx   = i_in_item.tile_address;
                            n_state = S_RD;
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_PUT: begin
                mem.wr_en          = 1'b1;
                mem.wr_symbol      = 1'b1;
                mem.wr_fg          = r_put_fg;
                mem.wr_addr        = r_idx;
                mem.wr_data.symbol = r_sym;
                mem.wr_data.fg     = i_cfg.pen_foreground;
                if (r_scroll_pend) begin
                    n_mode  = M_SCROLL;
                    n_idx   = '0;
                    n_last  = POS_W'(ncells - (POS_W+1)'(1));
                    n_state = S_SWEEP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SWEEP: begin
                case (r_mode)
                    M_SCROLL: begin
                        kind        = ({1'b0, r_idx} < keep) ? K_COPY : K_BLANKCH;
                        mem.rd_addr = r_idx + cols12;
                    end
                    M_DOWN: begin
                        kind        = K_COPY;
                        mem.rd_addr = r_idx + POS_W'(1);
                    end
                    M_UP: begin
                        kind        = K_COPY;
                        mem.rd_addr = r_idx - POS_W'(1);
                    end
                    default: kind = K_FILL;
                endcase
                mem.rd_en = (kind == K_COPY);
                n_pv      = 1'b1;
                n_pdst    = r_idx;
                n_pkind   = kind;
                if (r_idx == r_last) begin
                    n_state = S_DRAIN;
                end else if (r_mode == M_UP) begin
                    n_idx = r_idx - POS_W'(1);
                end else begin
                    n_idx = r_idx + POS_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = r_after_blank ? S_BLANK : S_FINISH;
            end
            S_BLANK: begin
                mem.wr_en   = 1'b1;
                mem.wr_symbol = 1'b1;
                mem.wr_fg   = 1'b1;
                mem.wr_bg   = 1'b1;
                mem.wr_addr = r_blank_pos;
                mem.wr_data = '{symbol: BLANK_CHAR, fg: i_cfg.pen_foreground,
                                bg: i_cfg.pen_background};
                n_state     = S_FINISH;
            end
            S_RD: begin
                mem.rd_en   = 1'b1;
                mem.rd_addr = r_idx;
                n_state     = S_RDW;
            end
            S_RDW: begin
                case (r_op)
                    OP_TICK: begin
                        mem.wr_en          = 1'b1;
                        mem.wr_symbol      = 1'b1;
                        mem.wr_addr        = r_idx;
                        mem.wr_data.symbol = i_rd_cell.symbol ^ BLINK_BIT;
                    end
                    OP_CURSOR_ON: n_saved   = i_rd_cell.symbol;
                    OP_READ:      n_rd_cell = i_rd_cell;
                    default:      n_rd_cell = r_rd_cell;
                endcase
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov                  = 1'b1;
                    n_out.cursor_pos      = r_cursor;
                    n_out.tile_char       = r_rd_cell.symbol;
                    n_out.tile_fg         = r_rd_cell.fg;
                    n_out.tile_bg         = r_rd_cell.bg;
                    n_out.command_full    = ((r_ce - r_cs) == COMMAND_LIMIT);
                    n_out.blink_active    = r_blink;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // delayed write half of the sweep pipeline
        if (r_pv) begin
            mem.wr_en     = 1'b1;
            mem.wr_addr   = r_pdst;
            mem.wr_symbol = 1'b1;
            case (r_pkind)
                K_COPY: begin
                    mem.wr_fg   = 1'b1;
                    mem.wr_bg   = 1'b1;
                    mem.wr_data = i_rd_cell;
                end
                K_BLANKCH: begin
                    mem.wr_data.symbol = BLANK_CHAR;
                end
                default: begin
                    mem.wr_fg   = 1'b1;
                    mem.wr_bg   = 1'b1;
                    mem.wr_data = '{symbol: BLANK_CHAR, fg: i_cfg.clear_foreground,
                                    bg: i_cfg.clear_background};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_cs     <= '0;
            r_ce     <= '0;
            r_blink  <= 1'b0;
            r_cd     <= '0;
            r_saved  <= '0;
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_cs     <= n_cs;
            r_ce     <= n_ce;
            r_blink  <= n_blink;
            r_cd     <= n_cd;
            r_saved  <= n_saved;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_sym         <= n_sym;
        r_put_fg      <= n_put_fg;
        r_scroll_pend <= n_scroll_pend;
        r_idx         <= n_idx;
        r_last        <= n_last;
        r_blank_pos   <= n_blank_pos;
        r_mode        <= n_mode;
        r_after_blank <= n_after_blank;
        r_pdst        <= n_pdst;
        r_pkind       <= n_pkind;
        r_out         <= n_out;
        r_rd_cell     <= n_rd_cell;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
    assign o_mem       = mem;

    `TTE_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !mem.wr_en)
    `TTE_ASSERT_IMP(a_no_rw_same_cell, i_clk, i_rst_n, mem.wr_en && mem.rd_en,
                    mem.wr_addr != mem.rd_addr)
    `TTE_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid,
                    r_state != S_IDLE)
    `TTE_ASSERT_IMP(a_pending_after_sweep, i_clk, i_rst_n, r_pv,
                    (r_state == S_SWEEP) || (r_state == S_DRAIN))

endmodule

@@ design/text_terminal_cell_engine.sv @@
// Character-cell terminal over a 4096-entry tile store (character, foreground and
// background per cell). Each accepted item runs one operation and returns exactly one
// result item. A tick that toggles the blink bit reads the cursor cell and writes it
// back with the bit flipped, and a tile read registers the addressed cell into the
// result. Clear walks the visible cells at one cell per cycle, and any scroll (line
// feed on the last row, putchar, right or down past the end) adds a walk of the same
// length. Backspace and insert walk the shifted span, one cell per cycle.
// The tile store has a single read port and a single write port: a walk reads one
// cell and writes the one before it in every cycle. A finished result is held in an
// output register, and the next item is taken while it waits. Software must issue
// clear before reading cells back.
module text_terminal_cell_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // item input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  tte_pkg::t_in_item    i_in_item,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tte_pkg::t_out_item   o_out_item
);
    import tte_pkg::*;

    t_cfg     cfg;
    t_mem_req mem_req;
    t_cell    rd_cell;

    // register file, all fields reset to their documented values
    tte_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: decodes the operation, walks the store, builds the result
    tte_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_mem       (mem_req),
        .i_rd_cell   (rd_cell)
    );

    // tile store, one read and one write per cycle, registered read data
    tte_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_cell (rd_cell)
    );

endmodule
